// ===== hw/rtl/wts_pkg.sv =====
// shared types and constants for the weekly temperature statistics block
package wts_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int TOTAL_W    = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [SAMPLE_W-1:0] MIN_INIT      = 8'd255;
	localparam logic [SAMPLE_W-1:0] THR_DEFAULT   = 8'd30;
	localparam logic [2:0]          HOT_DAYS_MAX  = 3'd7;

	typedef enum logic {
		KIND_DAY  = 1'b0,
		KIND_WEEK = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [2:0]          day_index;
		logic [SAMPLE_W-1:0] max_value;
		logic [SAMPLE_W-1:0] min_value;
		logic [TOTAL_W-1:0]  total;
		logic                hot_day;
		logic [2:0]          peak_day;
		logic [4:0]          peak_hour;
		logic [2:0]          hot_day_count;
		logic                last;
	} result_t;

	// fill state of the result queue seen by the statistics logic
	typedef struct packed {
		logic has_room;
		logic not_empty;
	} fifo_status_t;

endpackage

// ===== hw/rtl/wts_result_fifo.sv =====
// small result queue taking up to two items per cycle and giving one
module wts_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_a,
	input  logic                  push_b,
	input  wts_pkg::result_t      data_a,
	input  wts_pkg::result_t      data_b,
	input  logic                  pop,
	output wts_pkg::result_t      head,
	output wts_pkg::fifo_status_t status
);
	import wts_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic [FIFO_AW-1:0]   wr_ptr_b;
	logic [FIFO_CW-1:0]   n_push;

	assign wr_ptr_b = wr_ptr_q + 1'b1;
	assign n_push   = FIFO_CW'(push_a) + FIFO_CW'(push_b);

	// status: room for a full pair of items
	assign status.has_room  = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign status.not_empty = count_q != '0;
	assign head             = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_ptr_q] <= data_a;
		end
		if (push_b) begin
			mem_q[wr_ptr_b] <= data_b;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - FIFO_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue over depth");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_b |-> push_a)
		else $error("second item pushed without first");

endmodule

// ===== hw/rtl/weekly_temperature_statistics.sv =====
// top level of the weekly temperature statistics block
//
// One hourly sample enters per item on the input channel (in_valid/in_ready,
// payload sample). All statistics for the item are worked out in the cycle
// it is accepted and stored in the running registers; a day summary (and,
// after the last day, a week summary behind it) is written into a four-item
// result queue that feeds the output channel (out_valid/out_ready).
// Samples are taken one per cycle while in_ready is high; a result is
// written into the queue when its sample is accepted and reaches the output
// behind any older results. The week end gives two results, which the
// receiver takes one after the other. in_ready depends only on the queue
// fill: it drops while fewer than two slots are free, so a stalled receiver
// holds off the sender once at most four results are queued. cfg_we writes
// mean_threshold; the threshold times the hours per day is kept registered
// for the hot-day test. Reset clears all statistics, empties the queue and sets
// the threshold to its default of 30; there is no clearing pass.
module weekly_temperature_statistics #(
	parameter int HOURS_PER_DAY = 24,
	parameter int DAYS_PER_WEEK = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wts_pkg::SAMPLE_W-1:0] mean_threshold,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [wts_pkg::SAMPLE_W-1:0] sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         kind,
	output logic [2:0]                   day_index,
	output logic [wts_pkg::SAMPLE_W-1:0] max_value,
	output logic [wts_pkg::SAMPLE_W-1:0] min_value,
	output logic [wts_pkg::TOTAL_W-1:0]  total,
	output logic                         hot_day,
	output logic [2:0]                   peak_day,
	output logic [4:0]                   peak_hour,
	output logic [2:0]                   hot_day_count,
	output logic                         last
);
	import wts_pkg::*;

	localparam int HCW   = $clog2(HOURS_PER_DAY);
	localparam int DCW   = (DAYS_PER_WEEK > 1) ? $clog2(DAYS_PER_WEEK) : 1;
	localparam int SUM_W = SAMPLE_W + $clog2(HOURS_PER_DAY);
	localparam logic [HCW-1:0]   HOUR_LAST = HCW'(HOURS_PER_DAY - 1);
	localparam logic [DCW-1:0]   DAY_LAST  = DCW'(DAYS_PER_WEEK - 1);
	localparam logic [SUM_W-1:0] THR_RESET = SUM_W'(30 * HOURS_PER_DAY);

	logic [SUM_W-1:0]    thr_prod_q;
	logic [HCW-1:0]      hour_count_q;
	logic [DCW-1:0]      day_count_q;
	logic [SAMPLE_W-1:0] day_max_q, day_min_q;
	logic [SUM_W-1:0]    day_sum_q;
	logic [SAMPLE_W-1:0] week_max_q, week_min_q;
	logic [TOTAL_W-1:0]  week_sum_q;
	logic [DCW-1:0]      best_day_q;
	logic [HCW-1:0]      best_hour_q;
	logic [2:0]          hot_days_q;

	logic                in_fire;
	logic                day_end, week_end, hot;
	logic [SAMPLE_W-1:0] day_max_n, day_min_n, week_max_n, week_min_n;
	logic [SUM_W-1:0]    day_sum_n;
	logic [TOTAL_W:0]    week_sum_add;
	logic [TOTAL_W-1:0]  week_sum_n;
	logic [DCW-1:0]      best_day_n;
	logic [HCW-1:0]      best_hour_n;
	logic [2:0]          hot_days_n;
	logic [DCW+2:0]      day_ext, best_day_ext;
	logic [HCW+4:0]      best_hour_ext;
	result_t             day_res, week_res, head;
	fifo_status_t        fifo_st;

	assign in_fire = in_valid && in_ready;

	// running extrema and sums including this sample
	always_comb begin
		day_max_n    = (sample > day_max_q)  ? sample : day_max_q;
		day_min_n    = (sample < day_min_q)  ? sample : day_min_q;
		week_max_n   = (sample > week_max_q) ? sample : week_max_q;
		week_min_n   = (sample < week_min_q) ? sample : week_min_q;
		day_sum_n    = day_sum_q + SUM_W'(sample);
		week_sum_add = {1'b0, week_sum_q} + (TOTAL_W + 1)'(sample);
		week_sum_n   = week_sum_add[TOTAL_W] ? '1 : week_sum_add[TOTAL_W-1:0];
	end

	// peak position follows the last sample at or above the week maximum
	assign best_day_n  = (sample >= week_max_q) ? day_count_q  : best_day_q;
	assign best_hour_n = (sample >= week_max_q) ? hour_count_q : best_hour_q;

	// end of day and hot-day test
	assign day_end    = hour_count_q == HOUR_LAST;
	assign week_end   = day_count_q == DAY_LAST;
	assign hot        = day_sum_n >= thr_prod_q;
	assign hot_days_n = (hot && hot_days_q != HOT_DAYS_MAX) ? hot_days_q + 1'b1 : hot_days_q;

	// field-width views of the counters
	assign day_ext       = {3'b000, day_count_q};
	assign best_day_ext  = {3'b000, best_day_n};
	assign best_hour_ext = {5'b00000, best_hour_n};

	// result items
	always_comb begin
		day_res.kind          = KIND_DAY;
		day_res.day_index     = day_ext[2:0];
		day_res.max_value     = day_max_n;
		day_res.min_value     = day_min_n;
		day_res.total         = TOTAL_W'(day_sum_n);
		day_res.hot_day       = hot;
		day_res.peak_day      = best_day_ext[2:0];
		day_res.peak_hour     = best_hour_ext[4:0];
		day_res.hot_day_count = hot_days_n;
		day_res.last          = !week_end;

		week_res               = day_res;
		week_res.kind          = KIND_WEEK;
		week_res.max_value     = week_max_n;
		week_res.min_value     = week_min_n;
		week_res.total         = week_sum_n;
		week_res.hot_day       = 1'b0;
		week_res.last          = 1'b1;
	end

	// threshold register, kept as threshold times hours per day
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_prod_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_prod_q <= SUM_W'(mean_threshold * HOURS_PER_DAY);
		end
	end

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_count_q <= '0;
			day_count_q  <= '0;
			day_max_q    <= '0;
			day_min_q    <= MIN_INIT;
			day_sum_q    <= '0;
			week_max_q   <= '0;
			week_min_q   <= MIN_INIT;
			week_sum_q   <= '0;
			best_day_q   <= '0;
			best_hour_q  <= '0;
			hot_days_q   <= '0;
		end else if (in_fire) begin
			if (!day_end) begin
				hour_count_q <= hour_count_q + 1'b1;
				day_max_q    <= day_max_n;
				day_min_q    <= day_min_n;
				day_sum_q    <= day_sum_n;
				week_max_q   <= week_max_n;
				week_min_q   <= week_min_n;
				week_sum_q   <= week_sum_n;
				best_day_q   <= best_day_n;
				best_hour_q  <= best_hour_n;
			end else if (!week_end) begin
				hour_count_q <= '0;
				day_count_q  <= day_count_q + 1'b1;
				day_max_q    <= '0;
				day_min_q    <= MIN_INIT;
				day_sum_q    <= '0;
				week_max_q   <= week_max_n;
				week_min_q   <= week_min_n;
				week_sum_q   <= week_sum_n;
				best_day_q   <= best_day_n;
				best_hour_q  <= best_hour_n;
				hot_days_q   <= hot_days_n;
			end else begin
				hour_count_q <= '0;
				day_count_q  <= '0;
				day_max_q    <= '0;
				day_min_q    <= MIN_INIT;
				day_sum_q    <= '0;
				week_max_q   <= '0;
				week_min_q   <= MIN_INIT;
				week_sum_q   <= '0;
				best_day_q   <= '0;
				best_hour_q  <= '0;
				hot_days_q   <= '0;
			end
		end
	end

	// result queue
	wts_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (in_fire && day_end),
		.push_b (in_fire && day_end && week_end),
		.data_a (day_res),
		.data_b (week_res),
		.pop    (out_valid && out_ready),
		.head   (head),
		.status (fifo_st)
	);

	assign in_ready      = fifo_st.has_room;
	assign out_valid     = fifo_st.not_empty;
	assign kind          = head.kind;
	assign day_index     = head.day_index;
	assign max_value     = head.max_value;
	assign min_value     = head.min_value;
	assign total         = head.total;
	assign hot_day       = head.hot_day;
	assign peak_day      = head.peak_day;
	assign peak_hour     = head.peak_hour;
	assign hot_day_count = head.hot_day_count;
	assign last          = head.last;

	a_day_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && day_end |=> out_valid)
		else $error("day end gave no result");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_count_q <= HOUR_LAST)
		else $error("hour counter out of range");

	a_day_order: assert property (@(posedge clk) disable iff (!arst_n)
		hour_count_q != '0 |-> day_min_q <= day_max_q)
		else $error("day minimum above day maximum");

endmodule

// ===== tb/wts_checker.sv =====
`timescale 1ns / 1ps
// summary checker for the weekly temperature statistics block: predicts each summary and compares it
module wts_checker #(
	parameter int HOURS_PER_DAY = 24,
	parameter int DAYS_PER_WEEK = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wts_pkg::SAMPLE_W-1:0] mean_threshold,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [wts_pkg::SAMPLE_W-1:0] sample,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         kind,
	input  logic [2:0]                   day_index,
	input  logic [wts_pkg::SAMPLE_W-1:0] max_value,
	input  logic [wts_pkg::SAMPLE_W-1:0] min_value,
	input  logic [wts_pkg::TOTAL_W-1:0]  total,
	input  logic                         hot_day,
	input  logic [2:0]                   peak_day,
	input  logic [4:0]                   peak_hour,
	input  logic [2:0]                   hot_day_count,
	input  logic                         last,
	output int                           mismatches,
	output int                           outstanding,
	output int                           day_reports,
	output int                           week_reports,
	output int                           hot_reports
);
	import wts_pkg::*;

	// predicted statistics state
	logic [SAMPLE_W-1:0] threshold;
	logic [SAMPLE_W-1:0] day_hi;
	logic [SAMPLE_W-1:0] day_lo;
	logic [SAMPLE_W-1:0] week_hi;
	logic [SAMPLE_W-1:0] week_lo;
	int                  hour_no;
	int                  day_no;
	int                  day_total;
	int                  week_total;
	int                  peak_d;
	int                  peak_h;
	int                  hot_count;
	result_t             expected_summaries[$];

	task automatic clear_day();
		hour_no   = 0;
		day_hi    = '0;
		day_lo    = MIN_INIT;
		day_total = 0;
	endtask

	task automatic clear_week();
		clear_day();
		day_no     = 0;
		week_hi    = '0;
		week_lo    = MIN_INIT;
		week_total = 0;
		peak_d     = 0;
		peak_h     = 0;
		hot_count  = 0;
	endtask

	function automatic result_t make_summary(kind_t k, logic [SAMPLE_W-1:0] hi,
			logic [SAMPLE_W-1:0] lo, int sum, logic hot, logic fin);
		result_t r;
		r.kind          = k;
		r.day_index     = day_no[2:0];
		r.max_value     = hi;
		r.min_value     = lo;
		r.total         = sum[TOTAL_W-1:0];
		r.hot_day       = hot;
		r.peak_day      = peak_d[2:0];
		r.peak_hour     = peak_h[4:0];
		r.hot_day_count = hot_count[2:0];
		r.last          = fin;
		return r;
	endfunction

	function automatic string describe(result_t r);
		return $sformatf("kind=%0d day=%0d max=%0d min=%0d total=%0d hot=%0d peak=%0d/%0d hot_days=%0d last=%0d",
			r.kind, r.day_index, r.max_value, r.min_value, r.total, r.hot_day,
			r.peak_day, r.peak_hour, r.hot_day_count, r.last);
	endfunction

	// fold one sample into the running statistics, queue any summaries it closes
	task automatic fold_sample(logic [SAMPLE_W-1:0] s);
		logic hot;
		logic week_done;
		// greater-or-equal so that a repeated maximum moves the peak
		if (s >= week_hi) begin
			peak_d = day_no;
			peak_h = hour_no;
		end
		if (s > week_hi)
			week_hi = s;
		if (s < week_lo)
			week_lo = s;
		week_total += int'(s);
		if (week_total > 65535)
			week_total = 65535;
		if (s > day_hi)
			day_hi = s;
		if (s < day_lo)
			day_lo = s;
		day_total += int'(s);

		if (hour_no + 1 < HOURS_PER_DAY) begin
			hour_no++;
		end else begin
			// hot test on the exact sum, threshold as held at the end of the day
			hot = (day_total >= int'(threshold) * HOURS_PER_DAY);
			if (hot && hot_count < int'(HOT_DAYS_MAX))
				hot_count++;
			week_done = (day_no + 1 >= DAYS_PER_WEEK);
			expected_summaries.push_back(make_summary(KIND_DAY, day_hi, day_lo, day_total,
				hot, !week_done));
			if (!week_done) begin
				day_no++;
				clear_day();
			end else begin
				expected_summaries.push_back(make_summary(KIND_WEEK, week_hi, week_lo,
					week_total, 1'b0, 1'b1));
				clear_week();
			end
		end
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			threshold = THR_DEFAULT;
			clear_week();
			expected_summaries.delete();
			mismatches   = 0;
			outstanding  = 0;
			day_reports  = 0;
			week_reports = 0;
			hot_reports  = 0;
		end else begin
			got = {kind, day_index, max_value, min_value, total, hot_day,
				peak_day, peak_hour, hot_day_count, last};

			// compare a delivered summary with the oldest prediction
			if (out_valid && out_ready) begin
				if (kind == KIND_WEEK) begin
					week_reports++;
				end else begin
					day_reports++;
					if (hot_day)
						hot_reports++;
				end
				if (expected_summaries.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("checker: unexpected summary at %0t: %s", $time, describe(got));
				end else begin
					want = expected_summaries.pop_front();
					if (got.kind !== want.kind || got.day_index !== want.day_index ||
							got.max_value !== want.max_value ||
							got.min_value !== want.min_value ||
							got.total !== want.total || got.hot_day !== want.hot_day ||
							got.peak_day !== want.peak_day ||
							got.peak_hour !== want.peak_hour ||
							got.hot_day_count !== want.hot_day_count ||
							got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("checker: summary mismatch at %0t", $time);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end

			if (cfg_we)
				threshold = mean_threshold;
			if (in_valid && in_ready)
				fold_sample(sample);
			outstanding = expected_summaries.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for the weekly temperature statistics block: clock, reset, stimulus and verdict
module tb_top;
	import wts_pkg::*;

	localparam int HOURS       = 24;
	localparam int DAYS        = 7;
	localparam int ITEM_GOAL   = 1550;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 4;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                cfg_we         = 1'b0;
	logic [SAMPLE_W-1:0] mean_threshold = THR_DEFAULT;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample         = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic                kind;
	logic [2:0]          day_index;
	logic [SAMPLE_W-1:0] max_value;
	logic [SAMPLE_W-1:0] min_value;
	logic [TOTAL_W-1:0]  total;
	logic                hot_day;
	logic [2:0]          peak_day;
	logic [4:0]          peak_hour;
	logic [2:0]          hot_day_count;
	logic                last;

	int                  mismatches;
	int                  outstanding;
	int                  day_reports;
	int                  week_reports;
	int                  hot_reports;

	bit                  steady           = 1'b0;
	int                  stall_left       = 0;
	int                  quiet_cycles     = 0;
	int                  samples_sent     = 0;
	int                  days_sent        = 0;
	int                  threshold_writes = 0;
	logic [SAMPLE_W-1:0] day_plan [HOURS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	weekly_temperature_statistics #(
		.HOURS_PER_DAY(HOURS),
		.DAYS_PER_WEEK(DAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.mean_threshold(mean_threshold),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.day_index(day_index),
		.max_value(max_value),
		.min_value(min_value),
		.total(total),
		.hot_day(hot_day),
		.peak_day(peak_day),
		.peak_hour(peak_hour),
		.hot_day_count(hot_day_count),
		.last(last)
	);

	wts_checker #(
		.HOURS_PER_DAY(HOURS),
		.DAYS_PER_WEEK(DAYS)
	) stats_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.mean_threshold(mean_threshold),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.day_index(day_index),
		.max_value(max_value),
		.min_value(min_value),
		.total(total),
		.hot_day(hot_day),
		.peak_day(peak_day),
		.peak_hour(peak_hour),
		.hot_day_count(hot_day_count),
		.last(last),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.day_reports(day_reports),
		.week_reports(week_reports),
		.hot_reports(hot_reports)
	);

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_threshold();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'd0;
		if (roll == 1)
			return 8'd255;
		return SAMPLE_W'($urandom_range(0, 255));
	endfunction

	// receiver stalls
	always @(negedge clk) begin
		if (steady || stall_left == 0) begin
			out_ready  <= 1'b1;
			stall_left <= steady ? 0 : pick_gap();
		end else begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// offer one sample and hold it until accepted, then maybe idle
	task automatic send_sample(logic [SAMPLE_W-1:0] value);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= value;
		do
			@(posedge clk);
		while (!in_ready);
		samples_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop sending and wait until every summary has come out
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_threshold(logic [SAMPLE_W-1:0] value);
		drain_results();
		cfg_we         <= 1'b1;
		mean_threshold <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(negedge clk);
		threshold_writes++;
	endtask

	task automatic send_day(int write_hour, logic [SAMPLE_W-1:0] write_value);
		for (int h = 0; h < HOURS; h++) begin
			if (h == write_hour)
				write_threshold(write_value);
			send_sample(day_plan[h]);
		end
		days_sent++;
	endtask

	// fill one day of samples in one of several shapes
	task automatic plan_day();
		int style;
		int base;
		int span;
		int i;
		int j;
		int up;
		int down;
		int shift;
		style = $urandom_range(0, 99);
		if (style < 35) begin
			foreach (day_plan[h])
				day_plan[h] = SAMPLE_W'($urandom_range(0, 255));
		end else if (style < 55) begin
			// day total on the hot boundary, give or take one
			foreach (day_plan[h])
				day_plan[h] = mean_threshold;
			repeat (8) begin
				i    = $urandom_range(0, HOURS - 1);
				j    = $urandom_range(0, HOURS - 1);
				up   = 255 - int'(day_plan[i]);
				down = int'(day_plan[j]);
				span = $urandom_range(0, (up < down) ? up : down);
				day_plan[i] = SAMPLE_W'(int'(day_plan[i]) + span);
				day_plan[j] = SAMPLE_W'(int'(day_plan[j]) - span);
			end
			shift = int'($urandom_range(0, 2)) - 1;
			i     = $urandom_range(0, HOURS - 1);
			if (shift > 0 && day_plan[i] < 8'd255)
				day_plan[i] = day_plan[i] + 8'd1;
			else if (shift < 0 && day_plan[i] > 8'd0)
				day_plan[i] = day_plan[i] - 8'd1;
		end else if (style < 70) begin
			// narrow band
			base = $urandom_range(0, 255);
			span = $urandom_range(0, 8);
			foreach (day_plan[h])
				day_plan[h] = SAMPLE_W'((base + span > 255)
					? 255 - int'($urandom_range(0, span))
					: base + int'($urandom_range(0, span)));
		end else if (style < 80) begin
			// flat day, every hour ties the maximum
			if ($urandom_range(0, 3) == 0)
				base = $urandom_range(0, 1) ? 255 : 0;
			else
				base = $urandom_range(0, 255);
			foreach (day_plan[h])
				day_plan[h] = SAMPLE_W'(base);
		end else if (style < 90) begin
			foreach (day_plan[h])
				day_plan[h] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
		end else begin
			// cool day with a few spikes
			foreach (day_plan[h])
				day_plan[h] = SAMPLE_W'(($urandom_range(0, 3) == 0)
					? $urandom_range(200, 255) : $urandom_range(0, 40));
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed day: extremes, tied maxima, alternating bits, threshold change mid-day
		write_threshold(8'd0);
		day_plan = '{255, 0, 255, 1, 254, 128, 127, 0, 255, 85, 170, 15,
			240, 16, 255, 3, 252, 64, 192, 32, 224, 96, 160, 255};
		send_day(12, 8'd255);

		// random days, whole weeks with and without idling
		while (samples_sent < ITEM_GOAL) begin
			if (days_sent % DAYS == 0)
				steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				write_threshold(pick_threshold());
			else if ($urandom_range(0, 19) == 0)
				drain_results();
			plan_day();
			if ($urandom_range(0, 9) == 0)
				send_day($urandom_range(1, HOURS - 1), pick_threshold());
			else
				send_day(-1, '0);
		end

		drain_results();
		repeat (10) @(negedge clk);
		$display("tb_top: %0d samples over %0d days, %0d threshold writes",
			samples_sent, days_sent, threshold_writes);
		$display("tb_top: %0d day and %0d week summaries checked, %0d hot days, %0d mismatches",
			day_reports, week_reports, hot_reports, mismatches);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
